FILE: src/ipdt_pkg.sv
// ----------------------------------------------------------------------------
// ipdt_pkg
// Shared types and constants of the pulse-distance infrared frame transmitter.
// ----------------------------------------------------------------------------
package ipdt_pkg;

  // Frame geometry
  localparam int unsigned FrameBits = 32;
  localparam int unsigned SegCount  = 3 + 2 * FrameBits;
  localparam int unsigned SegW      = $clog2(SegCount);
  localparam int unsigned BitW      = $clog2(FrameBits);
  localparam int unsigned InBits    = 32;

  // Configuration port
  localparam int unsigned TickW     = 16;
  localparam int unsigned CfgIdxW   = 3;

  // Segment numbers of the header, the first data bit and the last segment
  localparam logic [SegW-1:0] SegHdrMark  = SegW'(0);
  localparam logic [SegW-1:0] SegHdrGap   = SegW'(1);
  localparam logic [SegW-1:0] SegHdrPulse = SegW'(2);
  localparam logic [SegW-1:0] SegFirstBit = SegW'(3);
  localparam logic [SegW-1:0] SegLast     = SegW'(SegCount - 1);

  typedef enum logic {
    KindStart = 1'b0,
    KindTick  = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHdrMark  = 3'd0,
    CfgHdrGap   = 3'd1,
    CfgHdrPulse = 3'd2,
    CfgShort    = 3'd3,
    CfgLong     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] hdr_mark;
    logic [TickW-1:0] hdr_gap;
    logic [TickW-1:0] hdr_pulse;
    logic [TickW-1:0] short_len;
    logic [TickW-1:0] long_len;
  } cfg_t;

  typedef struct packed {
    logic [TickW-1:0] len;
    logic             level;
  } seg_info_t;

  localparam cfg_t CfgReset = '{
    hdr_mark:  TickW'(130),
    hdr_gap:   TickW'(2300),
    hdr_pulse: TickW'(2300),
    short_len: TickW'(300),
    long_len:  TickW'(800)
  };

endpackage

FILE: src/ir_pulse_distance_frame_transmitter_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_transmitter_core
// Tick-driven pulse-distance infrared frame transmitter, top level.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless the output stalls; the state
// step and the segment lookup are combinational between the frame registers.
// Input is stalled only while a result is held by a stalled output.
// Reset: asynchronous, active low; block idle, carrier off, default lengths.
module ir_pulse_distance_frame_transmitter_core
  import ipdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [InBits-1:0]  frame_bits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               carrier_on_o,
  output logic               busy_res_o,
  output logic               frame_done_o
);

  cfg_t cfg;

  ipdt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ipdt_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .frame_bits_i (frame_bits_i),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .carrier_on_o (carrier_on_o),
    .busy_res_o   (busy_res_o),
    .frame_done_o (frame_done_o)
  );

endmodule

FILE: src/ipdt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ipdt_cfg_regs
// Segment length registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ipdt_cfg_regs
  import ipdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgHdrMark:  cfg_d.hdr_mark  = cfg_data_i;
        CfgHdrGap:   cfg_d.hdr_gap   = cfg_data_i;
        CfgHdrPulse: cfg_d.hdr_pulse = cfg_data_i;
        CfgShort:    cfg_d.short_len = cfg_data_i;
        CfgLong:     cfg_d.long_len  = cfg_data_i;
        default:     cfg_d = cfg_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/ipdt_seg_sel.sv
// ----------------------------------------------------------------------------
// ipdt_seg_sel
// Length and carrier level of one segment of the frame.
// ----------------------------------------------------------------------------
module ipdt_seg_sel
  import ipdt_pkg::*;
(
  input  logic [SegW-1:0]      seg_i,
  input  logic [FrameBits-1:0] frame_i,
  input  cfg_t                 cfg_i,
  output seg_info_t            info_o
);

  logic [SegW-1:0] bit_off;
  logic [BitW-1:0] bit_pos;
  logic [BitW-1:0] bit_sel;
  logic            bit_one;
  logic            second;

  // Two segments per data bit, most significant bit first
  assign bit_off = seg_i - SegFirstBit;
  assign bit_pos = bit_off[BitW:1];
  assign bit_sel = BitW'(FrameBits - 1) - bit_pos;
  assign bit_one = frame_i[bit_sel];
  assign second  = bit_off[0];

  always_comb begin
    unique case (seg_i)
      SegHdrMark: begin
        info_o = '{len: cfg_i.hdr_mark, level: 1'b1};
      end
      SegHdrGap: begin
        info_o = '{len: cfg_i.hdr_gap, level: 1'b0};
      end
      SegHdrPulse: begin
        info_o = '{len: cfg_i.hdr_pulse, level: 1'b1};
      end
      default: begin
        // zero: short off, long on; one: long off, short on
        info_o.level = second;
        info_o.len   = (bit_one ^ second) ? cfg_i.long_len : cfg_i.short_len;
      end
    endcase
  end

endmodule

FILE: src/ipdt_engine.sv
// ----------------------------------------------------------------------------
// ipdt_engine
// Frame state and result register; one transaction per cycle when not stalled.
// ----------------------------------------------------------------------------
module ipdt_engine
  import ipdt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [InBits-1:0] frame_bits_i,
  input  cfg_t              cfg_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              carrier_on_o,
  output logic              busy_res_o,
  output logic              frame_done_o
);

  logic [FrameBits-1:0] frame_q, frame_d;
  logic [SegW-1:0]      seg_q, seg_d;
  logic [TickW-1:0]     ticks_q, ticks_d;
  logic                 carrier_q, carrier_d;
  logic                 active_q, active_d;
  logic                 done_q, done_d;
  logic                 out_valid_q, out_valid_d;

  logic                 accept;
  logic                 is_tick;
  logic [SegW-1:0]      seg_next;
  logic [SegW-1:0]      seg_lookup;
  logic [2*InBits-1:0]  frame_ext;
  seg_info_t            info;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_tick    = (kind_e'(kind_i) == KindTick);
  assign seg_next   = seg_q + SegW'(1);
  assign seg_lookup = is_tick ? seg_next : SegHdrMark;
  assign frame_ext  = {{InBits{1'b0}}, frame_bits_i};

  // The header segments ignore the frame, so the stored frame serves a start too
  ipdt_seg_sel u_seg_sel (
    .seg_i   (seg_lookup),
    .frame_i (frame_q),
    .cfg_i   (cfg_i),
    .info_o  (info)
  );

  always_comb begin
    frame_d     = frame_q;
    seg_d       = seg_q;
    ticks_d     = ticks_q;
    carrier_d   = carrier_q;
    active_d    = active_q;
    done_d      = done_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
      done_d      = 1'b0;
      if (!is_tick) begin
        // abort any running frame and restart
        frame_d   = frame_ext[FrameBits-1:0];
        seg_d     = SegHdrMark;
        active_d  = 1'b1;
        ticks_d   = info.len;
        carrier_d = info.level;
      end else if (active_q) begin
        if (ticks_q <= TickW'(1)) begin
          if (seg_q == SegLast) begin
            seg_d     = SegHdrMark;
            ticks_d   = '0;
            carrier_d = 1'b0;
            active_d  = 1'b0;
            done_d    = 1'b1;
          end else begin
            seg_d     = seg_next;
            ticks_d   = info.len;
            carrier_d = info.level;
          end
        end else begin
          ticks_d = ticks_q - TickW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= '0;
      ticks_q     <= '0;
      carrier_q   <= 1'b0;
      active_q    <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      frame_q     <= '0;
    end else begin
      seg_q       <= seg_d;
      ticks_q     <= ticks_d;
      carrier_q   <= carrier_d;
      active_q    <= active_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      frame_q     <= frame_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign carrier_on_o = carrier_q;
  assign busy_res_o   = active_q;
  assign frame_done_o = done_q;

  a_idle_carrier_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (!carrier_q && seg_q == '0 && ticks_q == '0))
    else $error("idle with carrier or segment state left over");

  a_done_means_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !active_q)
    else $error("frame done flagged while still busy");

  a_seg_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q <= SegLast)
    else $error("segment index past the last segment");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      ($stable(seg_q) && $stable(ticks_q) && $stable(active_q) && $stable(done_q)))
    else $error("frame state moved while the result was held");

endmodule

FILE: dv/ir_pulse_distance_frame_transmitter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_transmitter_core_tb
// Self-checking bench for the infrared frame transmitter. A queue-fed driver
// sends start and tick transactions in random bursts. A monitor stalls the
// result channel on its own pattern and compares every result with a
// cycle-free model of the segment sequencer. Segment lengths are
// reprogrammed between phases: reset values, all ones, all zeros, the maximum
// value and small random settings.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_transmitter_core_tb;
  import ipdt_pkg::*;

  localparam int CycleLimit = 300000;

  typedef struct {
    kind_e             kind;
    logic [InBits-1:0] bits;
  } tx_item_t;

  typedef struct packed {
    logic carrier;
    logic busy;
    logic done;
  } line_state_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [TickW-1:0]   cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  kind_e              kind_i       = KindTick;
  logic [InBits-1:0]  frame_bits_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               carrier_on_o;
  logic               busy_res_o;
  logic               frame_done_o;

  ir_pulse_distance_frame_transmitter_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .frame_bits_i (frame_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .carrier_on_o (carrier_on_o),
    .busy_res_o   (busy_res_o),
    .frame_done_o (frame_done_o)
  );

  // Transmitter model state
  cfg_t             tx_lengths = CfgReset;
  logic [FrameBits-1:0] tx_bits  = '0;
  logic [SegW-1:0]  tx_seg     = '0;
  logic [TickW-1:0] tx_count   = '0;
  logic             tx_carrier = 1'b0;
  logic             tx_busy    = 1'b0;

  tx_item_t    pending_items[$];
  line_state_t line_states[$];

  int          err_count  = 0;
  int          cyc_count  = 0;
  int          burst_left = 0;
  int          gap_left   = 0;
  int          stall_tick = 0;
  logic        gap_mode   = 1'b0;
  int          stall_mode = 0;
  tx_item_t    next_item;
  line_state_t want;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Load length and carrier level of one segment
  function automatic void enter_segment(input logic [SegW-1:0] seg);
    logic [SegW-1:0] rel;
    logic            one;
    if (seg == SegHdrMark) begin
      tx_count   = tx_lengths.hdr_mark;
      tx_carrier = 1'b1;
    end else if (seg == SegHdrGap) begin
      tx_count   = tx_lengths.hdr_gap;
      tx_carrier = 1'b0;
    end else if (seg == SegHdrPulse) begin
      tx_count   = tx_lengths.hdr_pulse;
      tx_carrier = 1'b1;
    end else begin
      rel = seg - SegFirstBit;
      one = tx_bits[FrameBits - 1 - int'(rel[SegW-1:1])];
      tx_carrier = rel[0];
      if (rel[0]) begin
        tx_count = one ? tx_lengths.short_len : tx_lengths.long_len;
      end else begin
        tx_count = one ? tx_lengths.long_len : tx_lengths.short_len;
      end
    end
  endfunction

  function automatic void step_frame(input kind_e kind, input logic [InBits-1:0] bits);
    line_state_t r;
    r.done = 1'b0;
    if (kind == KindStart) begin
      tx_bits = bits[FrameBits-1:0];
      tx_seg  = SegHdrMark;
      tx_busy = 1'b1;
      enter_segment(SegHdrMark);
    end else if (tx_busy) begin
      if (tx_count <= TickW'(1)) begin
        if (tx_seg == SegLast) begin
          tx_seg     = '0;
          tx_count   = '0;
          tx_carrier = 1'b0;
          tx_busy    = 1'b0;
          r.done     = 1'b1;
        end else begin
          tx_seg = tx_seg + 1'b1;
          enter_segment(tx_seg);
        end
      end else begin
        tx_count = tx_count - 1'b1;
      end
    end
    r.carrier = tx_carrier;
    r.busy    = tx_busy;
    line_states.push_back(r);
  endfunction

  // Model side of a register write
  function automatic void note_write(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] d);
    case (idx)
      CfgHdrMark:  tx_lengths.hdr_mark  = d;
      CfgHdrGap:   tx_lengths.hdr_gap   = d;
      CfgHdrPulse: tx_lengths.hdr_pulse = d;
      CfgShort:    tx_lengths.short_len = d;
      CfgLong:     tx_lengths.long_len  = d;
      default: ;
    endcase
  endfunction

  // Ticks from start to frame end; a zero length still takes one tick
  function automatic int frame_ticks();
    int hm = (tx_lengths.hdr_mark  == 0) ? 1 : int'(tx_lengths.hdr_mark);
    int hg = (tx_lengths.hdr_gap   == 0) ? 1 : int'(tx_lengths.hdr_gap);
    int hp = (tx_lengths.hdr_pulse == 0) ? 1 : int'(tx_lengths.hdr_pulse);
    int sl = (tx_lengths.short_len == 0) ? 1 : int'(tx_lengths.short_len);
    int ll = (tx_lengths.long_len  == 0) ? 1 : int'(tx_lengths.long_len);
    return hm + hg + hp + FrameBits * (sl + ll);
  endfunction

  function automatic logic [InBits-1:0] rand_frame();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return InBits'(1) << $urandom_range(InBits - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_item(input kind_e kind, input logic [InBits-1:0] bits);
    tx_item_t it;
    it.kind = kind;
    it.bits = bits;
    pending_items.push_back(it);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    note_write(idx, d);
  endtask

  task automatic load_lengths(input logic [TickW-1:0] hm, input logic [TickW-1:0] hg,
                              input logic [TickW-1:0] hp, input logic [TickW-1:0] sl,
                              input logic [TickW-1:0] ll);
    write_reg(CfgHdrMark, hm);
    write_reg(CfgHdrGap, hg);
    write_reg(CfgHdrPulse, hp);
    write_reg(CfgShort, sl);
    write_reg(CfgLong, ll);
  endtask

  task automatic end_write();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued transaction is sent and every result is back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || line_states.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_idling(input int phase);
    @(negedge clk_i);
    gap_mode   <= phase[0];
    stall_mode <= phase % 3;
  endtask

  // Mostly whole frames with random content, some cut short, some noise
  task automatic gen_traffic(input int count);
    int n;
    int len;
    int pick;
    n = 0;
    // Continue whatever frame is running under the new lengths
    repeat ($urandom_range(6)) queue_item(KindTick, $urandom());
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        queue_item(KindStart, rand_frame());
        len = frame_ticks();
        if ($urandom_range(3) == 0) begin
          len = $urandom_range(len);
        end else begin
          repeat ($urandom_range(3)) queue_item(KindTick, $urandom());
        end
        repeat (len) queue_item(KindTick, $urandom());
        n += len + 1;
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1) == 0) begin
            queue_item(KindStart, rand_frame());
            n++;
          end else begin
            queue_item(KindTick, $urandom());
          end
        end
      end else begin
        queue_item(KindStart, rand_frame());
        queue_item(KindStart, rand_frame());
        n += 2;
      end
    end
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        step_frame(kind_i, frame_bits_i);
        if (burst_left > 0) begin
          burst_left--;
        end else if (gap_mode) begin
          burst_left = $urandom_range(15);
          gap_left   = $urandom_range(1, 5);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left == 0 && pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_valid_i   <= 1'b1;
          kind_i       <= next_item.kind;
          frame_bits_i <= next_item.bits;
        end else begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (line_states.size() == 0) begin
          flag_mismatch("result with no transaction pending");
        end else begin
          want = line_states.pop_front();
          if (carrier_on_o !== want.carrier)
            flag_mismatch($sformatf("carrier_on got %b exp %b", carrier_on_o, want.carrier));
          if (busy_res_o !== want.busy)
            flag_mismatch($sformatf("busy_res got %b exp %b", busy_res_o, want.busy));
          if (frame_done_o !== want.done)
            flag_mismatch($sformatf("frame_done got %b exp %b", frame_done_o, want.done));
        end
      end
      stall_tick = (stall_tick == 8) ? 0 : stall_tick + 1;
      case (stall_mode)
        1:       out_stall_i <= ($urandom_range(3) == 0);
        2:       out_stall_i <= (stall_tick < 3);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cyc_count++;
    if (cyc_count > CycleLimit) begin
      $display("FAIL ir_pulse_distance_frame_transmitter_core");
      $finish;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);

    // Reset lengths: idle ticks, start, abort by a second start
    set_idling(0);
    queue_item(KindTick, '0);
    queue_item(KindTick, '1);
    queue_item(KindStart, '1);
    repeat (3) queue_item(KindTick, $urandom());
    queue_item(KindStart, '0);
    repeat (2) queue_item(KindTick, '1);
    queue_item(KindStart, 32'h8000_0001);
    queue_item(KindTick, '0);
    drain();

    // One tick per segment; unused indexes must not alias a register
    load_lengths(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    for (int i = int'(CfgLong) + 1; i < (1 << CfgIdxW); i++) write_reg(CfgIdxW'(i), '1);
    end_write();
    set_idling(1);
    gen_traffic(220);
    drain();

    // Zero lengths behave as one tick
    load_lengths('0, '0, '0, '0, '0);
    end_write();
    set_idling(2);
    gen_traffic(220);
    drain();

    load_lengths(TickW'($urandom_range(4)), TickW'($urandom_range(4)),
                 TickW'($urandom_range(4)), TickW'($urandom_range(4)),
                 TickW'($urandom_range(4)));
    end_write();
    set_idling(3);
    gen_traffic(220);
    drain();

    // Longest segments: count down only
    load_lengths('1, '1, '1, '1, '1);
    end_write();
    set_idling(4);
    queue_item(KindStart, '1);
    repeat (20) queue_item(KindTick, $urandom());
    queue_item(KindStart, rand_frame());
    repeat (10) queue_item(KindTick, $urandom());
    drain();

    load_lengths(TickW'($urandom_range(1, 8)), TickW'($urandom_range(1, 8)),
                 TickW'($urandom_range(1, 8)), 16'd1, 16'd3);
    end_write();
    set_idling(5);
    gen_traffic(220);
    drain();

    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS ir_pulse_distance_frame_transmitter_core");
    end else begin
      $display("FAIL ir_pulse_distance_frame_transmitter_core");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ipdt_pkg.sv
src/ipdt_cfg_regs.sv
src/ipdt_seg_sel.sv
src/ipdt_engine.sv
src/ir_pulse_distance_frame_transmitter_core.sv
dv/ir_pulse_distance_frame_transmitter_core_tb.sv
